/* rtl/ppm_dec_pkg.sv */
`timescale 1ns / 1ps

package ppm_dec_pkg;

  // Number of channel slots in one PPM frame (1 to 16)
  localparam int NUM_CHANNELS = 8;
  localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam int TIME_W  = 16;
  localparam int SCORE_W = 8;
  localparam int SLOT_W  = 4;
  localparam int CFG_W   = 16;

  localparam logic [TIME_W:0]    GAP_TOLERANCE    = 17'd8000;
  localparam logic [SCORE_W-1:0] OVERFLOW_PENALTY = 8'd5;
  localparam logic [SCORE_W-1:0] BAD_EVENT_COST   = 8'd1;

  localparam logic [TIME_W-1:0]  FRAME_GAP_RESET = 16'd20000;
  localparam logic [TIME_W-1:0]  MIN_CHAN_RESET  = 16'd4000;
  localparam logic [TIME_W-1:0]  MAX_CHAN_RESET  = 16'd10000;
  localparam logic [SCORE_W-1:0] MAX_SCORE_RESET = 8'd50;

  localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(NUM_CHANNELS - 1);

  typedef enum logic [1:0] {
    CFG_FRAME_GAP = 2'd0,
    CFG_MIN_CHAN  = 2'd1,
    CFG_MAX_CHAN  = 2'd2,
    CFG_MAX_SCORE = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic               link_ok;
    logic [SCORE_W-1:0] error_score;
    logic               sync_found;
    logic               value_written;
    logic [SLOT_W-1:0]  channel_index;
    logic [TIME_W-1:0]  channel_value;
    logic               frame_complete;
  } result_t;

endpackage

/* rtl/ppm_frame_decoder.sv */
`timescale 1ns / 1ps

// PPM frame decoder for RC receivers.
//
// Input channel (in_valid / in_ready): one transaction per timer capture,
// carrying the pulse interval in ticks and a timer overflow flag.
// Output channel (out_valid / out_ready): exactly one result transaction per
// input transaction, in order: link health, error score, and what the event
// did (sync lock, channel store, frame end) with the addressed slot and its
// stored width.
// Config port: cfg_write with cfg_index / cfg_data writes one register;
// write only while no transaction is in flight.
//
// An accepted event's result is registered into the output register, or into the
// skid register if a result waits. Throughput: one event per cycle while in_ready
// is high, set by the single combinational decode step between state and result regs.
// A two-entry result buffer (output register plus skid register) lets a new
// event be accepted while a result waits; in_ready drops only when both hold
// results, and in_ready never depends combinationally on out_ready.
//
// Reset (synchronous): hunting for sync, slot pointer 0, all channel widths 0,
// score 0, config registers at their defaults, both result slots empty.

module ppm_frame_decoder
  import ppm_dec_pkg::*;
(
  input  logic               clk,
  input  logic               rst,

  input  logic               cfg_write,
  input  cfg_index_t         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic [TIME_W-1:0]  interval,
  input  logic               capture_ovf,

  output logic               out_valid,
  input  logic               out_ready,
  output logic               link_ok,
  output logic [SCORE_W-1:0] error_score,
  output logic               sync_found,
  output logic               value_written,
  output logic [SLOT_W-1:0]  channel_index,
  output logic [TIME_W-1:0]  channel_value,
  output logic               frame_complete
);

  // Configuration registers
  logic [TIME_W-1:0]  frame_gap_time;
  logic [TIME_W-1:0]  chan_time_floor;
  logic [TIME_W-1:0]  chan_time_ceil;
  logic [SCORE_W-1:0] max_error_score;

  // Decoder state
  logic                hunting_sync;
  logic [SLOT_W-1:0]   slot_pointer;
  logic [TIME_W-1:0]   channel_widths [NUM_CHANNELS];
  logic [SCORE_W-1:0]  error_counter;

  logic                hunting_sync_next;
  logic [SLOT_W-1:0]   slot_pointer_next;
  logic [SCORE_W-1:0]  error_counter_next;

  // Result buffer
  logic    out_reg_valid;
  result_t out_reg;
  logic    skid_valid;
  result_t skid;

  result_t            res;
  logic               in_fire;
  logic               out_fire;
  logic               out_free;

  logic [CH_IDX_W-1:0] p;
  logic [SLOT_W:0]     p_inc;
  logic                in_window;
  logic                chan_ok;
  logic                add_en;
  logic [SCORE_W-1:0]  add_amount;
  logic [SCORE_W:0]    score_sum;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_reg_valid && out_ready;
  assign out_free = !out_reg_valid || out_fire;

  // Sync window: interval strictly inside frame_gap_time +/- tolerance.
  // Rewritten without subtraction so small gap settings never wrap.
  assign in_window = (({1'b0, interval} + GAP_TOLERANCE) > {1'b0, frame_gap_time}) &&
                     ({1'b0, interval} < ({1'b0, frame_gap_time} + GAP_TOLERANCE));

  assign chan_ok = (interval > chan_time_floor) && (interval < chan_time_ceil);

  // Pointer past the frame folds back to slot 0
  assign p     = ({1'b0, slot_pointer} >= (SLOT_W+1)'(NUM_CHANNELS)) ? '0 :
                 slot_pointer[CH_IDX_W-1:0];
  assign p_inc = (SLOT_W+1)'(p) + 1'b1;

  always_comb begin
    hunting_sync_next  = hunting_sync;
    slot_pointer_next  = slot_pointer;
    add_en             = 1'b0;
    add_amount         = BAD_EVENT_COST;
    res                = '0;

    if (capture_ovf) begin
      add_en     = 1'b1;
      add_amount = OVERFLOW_PENALTY;
    end else if (hunting_sync) begin
      if (in_window) begin
        hunting_sync_next = 1'b0;
        slot_pointer_next = '0;
        res.sync_found    = 1'b1;
      end else begin
        add_en = 1'b1;
      end
    end else begin
      res.value_written = chan_ok;
      add_en            = !chan_ok;
      res.channel_index = SLOT_W'(p);
      res.channel_value = chan_ok ? interval : channel_widths[p];
      if (p_inc >= (SLOT_W+1)'(NUM_CHANNELS)) begin
        hunting_sync_next  = 1'b1;
        slot_pointer_next  = '0;
        res.frame_complete = 1'b1;
      end else begin
        slot_pointer_next = p_inc[SLOT_W-1:0];
      end
    end

    // Saturating score update; lock lowers it by one, stopping at zero
    score_sum = {1'b0, error_counter} + {1'b0, add_amount};
    if (add_en) begin
      error_counter_next = score_sum[SCORE_W] ? '1 : score_sum[SCORE_W-1:0];
    end else if (res.sync_found && (error_counter != '0)) begin
      error_counter_next = error_counter - 1'b1;
    end else begin
      error_counter_next = error_counter;
    end

    res.error_score = error_counter_next;
    res.link_ok     = (error_counter_next <= max_error_score);
  end

  // Config and decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_gap_time  <= FRAME_GAP_RESET;
      chan_time_floor <= MIN_CHAN_RESET;
      chan_time_ceil  <= MAX_CHAN_RESET;
      max_error_score <= MAX_SCORE_RESET;
      hunting_sync    <= 1'b1;
      slot_pointer    <= '0;
      error_counter   <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        channel_widths[i] <= '0;
      end
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_FRAME_GAP: frame_gap_time  <= cfg_data[TIME_W-1:0];
          CFG_MIN_CHAN:  chan_time_floor <= cfg_data[TIME_W-1:0];
          CFG_MAX_CHAN:  chan_time_ceil  <= cfg_data[TIME_W-1:0];
          CFG_MAX_SCORE: max_error_score <= cfg_data[SCORE_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        hunting_sync  <= hunting_sync_next;
        slot_pointer  <= slot_pointer_next;
        error_counter <= error_counter_next;
        if (res.value_written) begin
          channel_widths[p] <= interval;
        end
      end
    end
  end

  // Result buffer: output register with a skid register behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_reg_valid <= 1'b0;
      skid_valid    <= 1'b0;
    end else begin
      if (out_free) begin
        out_reg_valid <= skid_valid || in_fire;
        skid_valid    <= 1'b0;
      end else if (in_fire) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_reg <= skid_valid ? skid : res;
    end
    if (!out_free && in_fire) begin
      skid <= res;
    end
  end

  assign out_valid      = out_reg_valid;
  assign link_ok        = out_reg.link_ok;
  assign error_score    = out_reg.error_score;
  assign sync_found     = out_reg.sync_found;
  assign value_written  = out_reg.value_written;
  assign channel_index  = out_reg.channel_index;
  assign channel_value  = out_reg.channel_value;
  assign frame_complete = out_reg.frame_complete;

endmodule

/* rtl/ppm_dec_checker.sv */
`timescale 1ns / 1ps

module ppm_dec_checker
  import ppm_dec_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_ready,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               link_ok,
  input  logic [SCORE_W-1:0] error_score,
  input  logic               sync_found,
  input  logic               value_written,
  input  logic [SLOT_W-1:0]  channel_index,
  input  logic [TIME_W-1:0]  channel_value,
  input  logic               frame_complete
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(error_score) && $stable(channel_value))
    else $error("result changed while stalled");

  // An event either locks sync or touches a slot, never both
  a_sync_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && sync_found |-> !value_written && !frame_complete && channel_index == '0)
    else $error("sync lock reported together with slot activity");

  // Frame ends only on the last slot
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_complete |-> channel_index == LAST_SLOT)
    else $error("frame complete on a slot other than the last");

  // A missing link needs a nonzero score
  a_link_score: assert property (@(posedge clk) disable iff (rst)
    out_valid && !link_ok |-> error_score != '0)
    else $error("link reported missing with zero score");

  // Reset empties the result buffer
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("result buffer not empty after reset");

endmodule

bind ppm_frame_decoder ppm_dec_checker u_ppm_dec_checker (.*);

/* verif/tb_ppm_frame_decoder.sv */
`timescale 1ns / 1ps

module tb_ppm_frame_decoder;
  import ppm_dec_pkg::*;

  // ---------------------------------------------------------------------------
  // DUT ports: every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  cfg_index_t         cfg_index = CFG_FRAME_GAP;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [TIME_W-1:0]  interval = '0;
  logic               capture_ovf = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               link_ok;
  logic [SCORE_W-1:0] error_score;
  logic               sync_found;
  logic               value_written;
  logic [SLOT_W-1:0]  channel_index;
  logic [TIME_W-1:0]  channel_value;
  logic               frame_complete;

  ppm_frame_decoder dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .interval       (interval),
    .capture_ovf    (capture_ovf),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .link_ok        (link_ok),
    .error_score    (error_score),
    .sync_found     (sync_found),
    .value_written  (value_written),
    .channel_index  (channel_index),
    .channel_value  (channel_value),
    .frame_complete (frame_complete)
  );

  // 12 ns clock
  initial begin
    forever #6 clk = ~clk;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #(10_000_000);
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Decoder mirror: configuration and state as the DUT should hold them
  // ---------------------------------------------------------------------------
  int                gap_nominal;
  int                chan_min;
  int                chan_max;
  int                score_limit;
  bit                hunting;
  int                slot;
  logic [TIME_W-1:0] widths [NUM_CHANNELS];
  int                score;

  // Results predicted for accepted events, oldest first
  result_t pending_results [$];

  // Shared knobs and statistics
  bit idle_on  = 1'b1;   // random gaps on both sides
  int hold_off = 0;      // long receiver stall request, in cycles
  int fail_count;
  int events_sent;
  int results_seen;
  int frames_seen;
  int locks_seen;
  int peak_score;

  function automatic void score_bump(input int amount);
    score = (score + amount > 255) ? 255 : score + amount;
  endfunction

  // Apply one capture event to the mirror and return the result it must produce
  function automatic result_t decode_capture(input logic [TIME_W-1:0] iv, input logic ovf);
    result_t r;
    int      lo;
    int      hi;
    int      p;
    r = '0;
    if (ovf) begin
      // overflow: penalty only, nothing else moves
      score_bump(int'(OVERFLOW_PENALTY));
    end else if (hunting) begin
      // window is signed and strict on both sides
      lo = gap_nominal - int'(GAP_TOLERANCE);
      hi = gap_nominal + int'(GAP_TOLERANCE);
      if (int'(iv) > lo && int'(iv) < hi) begin
        hunting = 1'b0;
        slot    = 0;
        if (score != 0) score--;
        r.sync_found = 1'b1;
      end else begin
        score_bump(1);
      end
    end else begin
      p = (slot >= NUM_CHANNELS) ? 0 : slot;
      if (int'(iv) > chan_min && int'(iv) < chan_max) begin
        widths[p]       = iv;
        r.value_written = 1'b1;
      end else begin
        score_bump(1);
      end
      r.channel_index = SLOT_W'(p);
      r.channel_value = widths[p];
      p++;
      if (p >= NUM_CHANNELS) begin
        hunting          = 1'b1;
        p                = 0;
        r.frame_complete = 1'b1;
      end
      slot = p;
    end
    r.link_ok     = (score <= score_limit);
    r.error_score = SCORE_W'(score);
    return r;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on) return 0;
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Interval that lands inside the current sync window
  function automatic logic [TIME_W-1:0] gap_in_window();
    int lo;
    int hi;
    lo = gap_nominal - int'(GAP_TOLERANCE) + 1;
    hi = gap_nominal + int'(GAP_TOLERANCE) - 1;
    if (lo < 0) lo = 0;
    if (hi > 65535) hi = 65535;
    return TIME_W'($urandom_range(hi, lo));
  endfunction

  // Interval strictly between min and max, or anything if that range is empty
  function automatic logic [TIME_W-1:0] chan_in_range();
    if (chan_max - chan_min < 2) return TIME_W'($urandom);
    return TIME_W'($urandom_range(chan_max - 1, chan_min + 1));
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one capture transaction, valid held until accepted.
  // Called and returns at a rising edge; in_valid stays high on return.
  // ---------------------------------------------------------------------------
  task automatic send_capture(input logic [TIME_W-1:0] iv, input logic ovf);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    interval    <= iv;
    capture_ovf <= ovf;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(decode_capture(iv, ovf));
    events_sent++;
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write all four registers back to back; only called with the DUT idle
  task automatic set_config(input int gap, input int cmin, input int cmax, input int limit);
    cfg_write <= 1'b1;
    cfg_index <= CFG_FRAME_GAP;
    cfg_data  <= CFG_W'(gap);
    @(posedge clk);
    gap_nominal = gap;
    cfg_index <= CFG_MIN_CHAN;
    cfg_data  <= CFG_W'(cmin);
    @(posedge clk);
    chan_min = cmin;
    cfg_index <= CFG_MAX_CHAN;
    cfg_data  <= CFG_W'(cmax);
    @(posedge clk);
    chan_max = cmax;
    cfg_index <= CFG_MAX_SCORE;
    cfg_data  <= CFG_W'(limit);
    @(posedge clk);
    score_limit = limit;
    cfg_write <= 1'b0;
  endtask

  // Sync gap followed by one slot per channel, with a little noise mixed in
  task automatic send_frame();
    int pick;
    if ($urandom_range(0, 9) == 0) send_capture(TIME_W'($urandom), 1'b0);
    else send_capture(gap_in_window(), 1'b0);
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) send_capture(TIME_W'($urandom), 1'b1);
      else if (pick < 14) send_capture(TIME_W'($urandom), 1'b0);
      else send_capture(chan_in_range(), 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random ready, plus the long hold-off when requested
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int idle_len;
    idle_len = 0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        hold_off--;
      end else if (idle_len > 0) begin
        out_ready <= 1'b0;
        idle_len--;
      end else begin
        out_ready <= 1'b1;
        idle_len = pick_gap();
      end
    end
  end

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Every result transaction is matched against the oldest prediction
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result transaction with no event pending");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("link_ok", int'(want.link_ok), int'(link_ok));
        check_field("error_score", int'(want.error_score), int'(error_score));
        check_field("sync_found", int'(want.sync_found), int'(sync_found));
        check_field("value_written", int'(want.value_written), int'(value_written));
        check_field("channel_index", int'(want.channel_index), int'(channel_index));
        check_field("channel_value", int'(want.channel_value), int'(channel_value));
        check_field("frame_complete", int'(want.frame_complete), int'(frame_complete));
      end
      if (frame_complete) frames_seen++;
      if (sync_found) locks_seen++;
      if (int'(error_score) > peak_score) peak_score = int'(error_score);
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset defaults: lock at zero score, slot bounds, overflow while locked,
  // window edges, rereading stored widths on the next frame
  task automatic test_directed_frame();
    send_capture(16'd20000, 1'b0);   // lock, score already 0
    send_capture(16'd4000,  1'b0);   // equal to min: rejected
    send_capture(16'd4001,  1'b0);
    send_capture(16'd9999,  1'b0);
    send_capture(16'd10000, 1'b0);   // equal to max: rejected
    send_capture(16'hFFFF,  1'b1);   // overflow mid-frame, pointer holds
    send_capture(16'hFFFF,  1'b0);
    send_capture(16'h0000,  1'b0);
    send_capture(16'd7000,  1'b0);
    send_capture(16'd5000,  1'b0);   // last slot, back to hunting
    send_capture(16'd12000, 1'b0);   // lower window edge is exclusive
    send_capture(16'd28000, 1'b0);   // upper edge too
    send_capture(16'h0000,  1'b1);   // overflow while hunting
    send_capture(16'd12001, 1'b0);   // lock, score drops by one
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (i % 3 == 0) send_capture(16'd3, 1'b0);   // miss keeps old width
      else send_capture(TIME_W'(5555 + i), 1'b0);
    end
    send_capture(16'd27999, 1'b0);
    // finish this frame so the next test starts out hunting
    for (int i = 0; i < NUM_CHANNELS; i++) send_capture(16'd6000, 1'b0);
    drain_results();
  endtask

  // Register extremes, including a window whose lower edge sits at zero and one past 16 bits
  task automatic test_config_extremes();
    set_config(8000, 0, 65535, 0);
    send_capture(16'd0, 1'b0);       // lower bound 0 is exclusive
    send_capture(16'd1, 1'b0);
    send_capture(16'd0, 1'b0);
    send_capture(16'd1, 1'b0);
    send_capture(16'd65534, 1'b0);
    send_capture(16'd65535, 1'b0);
    for (int i = 0; i < NUM_CHANNELS - 4; i++) send_capture(TIME_W'($urandom), 1'b0);
    drain_results();
    set_config(65535, 65535, 0, 255);
    send_capture(16'd57535, 1'b0);   // exactly lo: miss
    send_capture(16'd65535, 1'b0);   // upper bound beyond 16 bits
    for (int i = 0; i < NUM_CHANNELS; i++) send_capture(TIME_W'($urandom), 1'b0);
    drain_results();
  endtask

  // Mostly well-formed frames under default, random and corner settings
  task automatic test_random_frames();
    set_config(int'(FRAME_GAP_RESET), int'(MIN_CHAN_RESET), int'(MAX_CHAN_RESET),
               int'(MAX_SCORE_RESET));
    repeat (12) send_frame();
    drain_results();
    repeat (3) begin
      set_config($urandom_range(0, 65535), $urandom_range(0, 30000),
                 $urandom_range(20000, 65535), $urandom_range(0, 255));
      repeat (15) send_frame();
      drain_results();
    end
    // no idling on either side for this stretch
    idle_on = 1'b0;
    set_config(65535, 0, 65535, 255);
    repeat (20) send_frame();
    drain_results();
    idle_on = 1'b1;
    // gap below the tolerance, empty channel range, zero score limit
    set_config(0, 65535, 0, 0);
    repeat (10) send_frame();
    drain_results();
  endtask

  // Receiver stops for a long stretch while events keep coming
  task automatic test_input_backpressure();
    set_config(int'(FRAME_GAP_RESET), int'(MIN_CHAN_RESET), int'(MAX_CHAN_RESET),
               int'(MAX_SCORE_RESET));
    hold_off = 200;
    repeat (30) send_frame();
    drain_results();
  endtask

  // Overflow burst drives the score into saturation, then frames pull it back
  task automatic test_link_loss();
    set_config(int'(FRAME_GAP_RESET), int'(MIN_CHAN_RESET), int'(MAX_CHAN_RESET),
               $urandom_range(0, 255));
    repeat (70) send_capture(TIME_W'($urandom), 1'b1);
    repeat (10) send_frame();
    drain_results();
  endtask

  // Unstructured events, any interval, overflow at random
  task automatic test_random_noise();
    set_config($urandom_range(0, 65535), $urandom_range(0, 65535),
               $urandom_range(0, 65535), $urandom_range(0, 255));
    repeat (100) send_capture(TIME_W'($urandom), 1'($urandom_range(0, 1)));
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    gap_nominal = int'(FRAME_GAP_RESET);
    chan_min    = int'(MIN_CHAN_RESET);
    chan_max    = int'(MAX_CHAN_RESET);
    score_limit = int'(MAX_SCORE_RESET);
    hunting     = 1'b1;
    slot        = 0;
    score       = 0;
    foreach (widths[i]) widths[i] = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_frame();
    test_config_extremes();
    test_random_frames();
    test_input_backpressure();
    test_link_loss();
    test_random_noise();

    drain_results();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d predicted results never arrived", pending_results.size());
      fail_count++;
    end

    $display("Sent %0d capture events, checked %0d results.", events_sent, results_seen);
    $display("Saw %0d sync locks, %0d full frames, score peaked at %0d.",
             locks_seen, frames_seen, peak_score);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
